// File: rtl/core/lfs_pkg.sv
`timescale 1ns / 1ps
package lfs_pkg;

	// defaults for the top-level parameters
	localparam int PATTERN_MAX_DEF = 32;
	localparam int LINE_BYTES_DEF  = 1024;
	localparam int COUNT_WIDTH_DEF = 32;

	// pattern storage held by the register block
	localparam int PAT_BYTES = 32;
	localparam int PAT_WORDS = 4;
	localparam int LEN_W     = 6;

	// register port
	localparam int APB_DW = 64;
	localparam int APB_AW = 6;

	localparam logic [2:0] REG_PATTERN_LENGTH = 3'd0;
	localparam logic [2:0] REG_FOLD_CASE      = 3'd1;
	localparam logic [2:0] REG_INVERT_SELECT  = 3'd2;
	localparam logic [2:0] REG_PATTERN_WORD_A = 3'd3;
	localparam logic [2:0] REG_PATTERN_WORD_B = 3'd4;
	localparam logic [2:0] REG_PATTERN_WORD_C = 3'd5;
	localparam logic [2:0] REG_PATTERN_WORD_D = 3'd6;

	// character codes
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_NUL     = 8'h00;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET  = 8'd32;

	// result kinds
	localparam logic RES_LINE    = 1'b0;
	localparam logic RES_SUMMARY = 1'b1;

	// result beat layout on the master tdata
	localparam int OUT_TDATA_W = 48;
	localparam int SEL_BIT     = 0;
	localparam int LEN_LSB     = 1;
	localparam int CNT_LSB     = 11;
	localparam int ANY_BIT     = 43;

	// result queue
	localparam int OUTQ_DEPTH = 4;

	typedef struct packed {
		logic       step;
		logic       clr;
		logic       fresh;
		logic       fold_case;
		logic [7:0] byte_fold;
	} cell_ctl_t;

	typedef struct packed {
		logic len_zero;
		logic fold_case;
		logic invert_select;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic        sel;
		logic [9:0]  len;
		logic [31:0] count;
		logic        any;
		logic        last;
	} result_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ic);
		logic [7:0] r;
		r = c;
		if (ic && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

// File: rtl/core/line_substring_filter.sv
`timescale 1ns / 1ps
// Line-oriented substring filter.
// Text enters one byte per beat on the s_axis channel; tlast marks end of
// stream (the data byte of that beat is ignored). Lines end at a newline or
// when a line already holds LINE_BYTES-1 bytes; the byte at such a split is
// kept as the first byte of the next line.
// Each finished line gives one verdict beat on m_axis (tuser 0); end of stream
// gives a pending non-empty line's verdict and then a summary beat (tuser 1).
// m_axis tlast marks the final beat caused by one input beat.
// A row of match cells, one per pattern byte, holds the shift-and prefix and
// advances once per byte, so one byte is taken every cycle while the queue
// has room. Results leave through a four-entry queue.
// s_axis_tready drops while the queue could not take two more beats, so a
// stalled receiver backs up into the sender after a few beats.
// Pattern and options must be written over the register port only while the
// block is idle; the block itself does not enforce this. Reset clears line
// state, counts, registers and the result queue; the block is ready out of reset.
module line_substring_filter #(
	parameter int PATTERN_MAX = lfs_pkg::PATTERN_MAX_DEF,
	parameter int LINE_BYTES  = lfs_pkg::LINE_BYTES_DEF,
	parameter int COUNT_WIDTH = lfs_pkg::COUNT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// register port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lfs_pkg::APB_AW-1:0]      paddr,
	input  logic [lfs_pkg::APB_DW-1:0]      pwdata,
	output logic [lfs_pkg::APB_DW-1:0]      prdata,
	output logic                           pready,
	// text input
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [7:0] text_byte
	input  logic                           s_axis_tlast,  // end_of_stream
	// results
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [0] line_selected, [10:1] line_length, [42:11] selected_count,
	// [43] any_selected, [47:44] zero
	output logic [lfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tuser,  // result_kind
	output logic                           m_axis_tlast   // last_result
);
	import lfs_pkg::*;

	localparam int CELLS = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
	localparam int LB_W  = $clog2(LINE_BYTES);

	cfg_t                   cfg;
	logic [CELLS*8-1:0]     pat_bytes;
	logic [CELLS-1:0]       active;
	logic [CELLS-1:0]       last;
	logic [CELLS:0]         link;
	logic [CELLS-1:0]       cell_hit;
	cell_ctl_t              ctl;

	logic                   line_hit_q;
	logic                   stopped_q;
	logic [LB_W-1:0]        bytes_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   seen_q;

	logic                   acc;
	logic                   eos;
	logic [7:0]             in_byte;
	logic                   is_nl;
	logic                   full;
	logic                   fresh;
	logic                   finish;
	logic                   take;
	logic                   verdict;
	logic                   base_stopped;
	logic                   base_hit;
	logic [LB_W-1:0]        base_bytes;
	logic [COUNT_WIDTH-1:0] count_f;
	logic                   seen_f;
	logic [COUNT_WIDTH+31:0] count_ext;
	logic [LB_W+9:0]        len_ext;
	result_t                line_res;
	result_t                sum_res;
	result_t                res0;
	logic                   push0;
	logic                   push1;
	logic                   room;
	result_t                out_res;

	lfs_regs #(
		.CELLS(CELLS)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cfg      (cfg),
		.pat_bytes(pat_bytes),
		.active   (active),
		.last     (last)
	);

	// input decode
	assign s_axis_tready = room;
	assign acc     = s_axis_tvalid & s_axis_tready;
	assign eos     = s_axis_tlast;
	assign in_byte = s_axis_tdata;
	assign is_nl   = (in_byte == CHAR_NEWLINE);
	assign full    = (bytes_q >= LB_W'(LINE_BYTES - 1));
	assign fresh   = eos | is_nl | full;
	assign finish  = acc & (eos ? (bytes_q != '0) : (is_nl | full));
	assign take    = acc & ~eos & ~is_nl;

	// state the incoming byte builds on, after a line split
	assign base_stopped = fresh ? 1'b0 : stopped_q;
	assign base_hit     = fresh ? 1'b0 : line_hit_q;
	assign base_bytes   = fresh ? '0 : bytes_q;

	// control for the cell row
	assign ctl.step        = take & ~base_stopped & (in_byte != CHAR_NUL) & ~cfg.len_zero;
	assign ctl.clr         = acc & fresh;
	assign ctl.fresh       = fresh;
	assign ctl.fold_case   = cfg.fold_case;
	assign ctl.byte_fold   = fold_byte(in_byte, cfg.fold_case);

	// shift-and cell row, prefix bits passed from cell to cell
	assign link[0] = 1'b1;
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		lfs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.pat_byte (pat_bytes[i*8 +: 8]),
			.active   (active[i]),
			.is_last  (last[i]),
			.carry_in (link[i]),
			.carry_out(link[i+1]),
			.hit      (cell_hit[i])
		);
	end

	// verdict and saturating count for the finished line
	assign verdict = (cfg.len_zero | line_hit_q) ^ cfg.invert_select;
	always_comb begin
		count_f = count_q;
		if (finish && verdict && !(&count_q)) begin
			count_f = count_q + COUNT_WIDTH'(1);
		end
	end
	assign seen_f    = seen_q | (finish & verdict);
	assign count_ext = {32'd0, count_f};
	assign len_ext   = {10'd0, bytes_q};

	// line and count state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_hit_q <= 1'b0;
			stopped_q  <= 1'b0;
			bytes_q    <= '0;
			count_q    <= '0;
			seen_q     <= 1'b0;
		end else if (acc) begin
			if (take) begin
				line_hit_q <= base_hit | (|cell_hit);
				stopped_q  <= base_stopped | (in_byte == CHAR_NUL);
				bytes_q    <= base_bytes + LB_W'(1);
			end else begin
				line_hit_q <= 1'b0;
				stopped_q  <= 1'b0;
				bytes_q    <= '0;
			end
			if (eos) begin
				count_q <= '0;
				seen_q  <= 1'b0;
			end else begin
				count_q <= count_f;
				seen_q  <= seen_f;
			end
		end
	end

	// result beats
	always_comb begin
		line_res.kind  = RES_LINE;
		line_res.sel   = verdict;
		line_res.len   = len_ext[9:0];
		line_res.count = count_ext[31:0];
		line_res.any   = seen_f;
		line_res.last  = ~eos;

		sum_res.kind  = RES_SUMMARY;
		sum_res.sel   = 1'b0;
		sum_res.len   = '0;
		sum_res.count = count_ext[31:0];
		sum_res.any   = seen_f;
		sum_res.last  = 1'b1;
	end

	assign push0 = finish | (acc & eos);
	assign push1 = finish & eos;
	assign res0  = finish ? line_res : sum_res;

	lfs_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push0    (push0),
		.push1    (push1),
		.res0     (res0),
		.res1     (sum_res),
		.room     (room),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res  (out_res)
	);

	// pack the result beat
	assign m_axis_tdata = {4'd0, out_res.any, out_res.count, out_res.len, out_res.sel};
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.last;

endmodule

// File: rtl/core/lfs_cell.sv
`timescale 1ns / 1ps
module lfs_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  lfs_pkg::cell_ctl_t ctl,
	input  logic [7:0]        pat_byte,
	input  logic              active,
	input  logic              is_last,
	input  logic              carry_in,
	output logic              carry_out,
	output logic              hit
);
	import lfs_pkg::*;

	logic prefix_q;
	logic match_d;

	// prefix bit extends when the neighbor's prefix held and this pattern byte matches
	assign match_d = carry_in & active & (fold_byte(pat_byte, ctl.fold_case) == ctl.byte_fold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= 1'b0;
		end else if (ctl.step) begin
			prefix_q <= match_d;
		end else if (ctl.clr) begin
			prefix_q <= 1'b0;
		end
	end

	// a new line starts with no prefix handed on
	assign carry_out = prefix_q & ~ctl.fresh;
	assign hit       = ctl.step & match_d & is_last;

endmodule

// File: rtl/core/lfs_regs.sv
`timescale 1ns / 1ps
module lfs_regs #(
	parameter int CELLS = lfs_pkg::PAT_BYTES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [lfs_pkg::APB_AW-1:0] paddr,
	input  logic [lfs_pkg::APB_DW-1:0] pwdata,
	output logic [lfs_pkg::APB_DW-1:0] prdata,
	output logic                      pready,
	output lfs_pkg::cfg_t             cfg,
	output logic [CELLS*8-1:0]        pat_bytes,
	output logic [CELLS-1:0]          active,
	output logic [CELLS-1:0]          last
);
	import lfs_pkg::*;

	logic [LEN_W-1:0]  plen_q;
	logic              icase_q;
	logic              invert_q;
	logic [APB_DW-1:0] word_q [PAT_WORDS];
	logic [2:0]        reg_idx;
	logic              wr_en;
	logic [LEN_W-1:0]  clamp_len;
	logic [LEN_W-1:0]  eff_len;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign wr_en   = psel & penable & pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q   <= '0;
			icase_q  <= 1'b0;
			invert_q <= 1'b0;
			for (int w = 0; w < PAT_WORDS; w++) begin
				word_q[w] <= '0;
			end
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PATTERN_LENGTH: plen_q   <= pwdata[LEN_W-1:0];
				REG_FOLD_CASE:      icase_q  <= pwdata[0];
				REG_INVERT_SELECT:  invert_q <= pwdata[0];
				REG_PATTERN_WORD_A: word_q[0] <= pwdata;
				REG_PATTERN_WORD_B: word_q[1] <= pwdata;
				REG_PATTERN_WORD_C: word_q[2] <= pwdata;
				REG_PATTERN_WORD_D: word_q[3] <= pwdata;
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_PATTERN_LENGTH: prdata = {{(APB_DW-LEN_W){1'b0}}, plen_q};
			REG_FOLD_CASE:      prdata = {{(APB_DW-1){1'b0}}, icase_q};
			REG_INVERT_SELECT:  prdata = {{(APB_DW-1){1'b0}}, invert_q};
			REG_PATTERN_WORD_A: prdata = word_q[0];
			REG_PATTERN_WORD_B: prdata = word_q[1];
			REG_PATTERN_WORD_C: prdata = word_q[2];
			REG_PATTERN_WORD_D: prdata = word_q[3];
			default:            prdata = '0;
		endcase
	end

	// pattern bytes for the cells
	for (genvar i = 0; i < CELLS; i++) begin : g_pat
		assign pat_bytes[i*8 +: 8] = word_q[i/8][(i%8)*8 +: 8];
	end

	// effective length: clamp, then stop at the first zero pattern byte
	assign clamp_len = (plen_q > LEN_W'(CELLS)) ? LEN_W'(CELLS) : plen_q;

	always_comb begin
		eff_len = clamp_len;
		for (int i = CELLS - 1; i >= 0; i--) begin
			if (LEN_W'(i) < clamp_len && pat_bytes[i*8 +: 8] == CHAR_NUL) begin
				eff_len = LEN_W'(i);
			end
		end
	end

	for (genvar i = 0; i < CELLS; i++) begin : g_mask
		assign active[i] = LEN_W'(i) < eff_len;
		assign last[i]   = LEN_W'(i + 1) == eff_len;
	end

	assign cfg.len_zero      = (eff_len == '0);
	assign cfg.fold_case     = icase_q;
	assign cfg.invert_select = invert_q;

endmodule

// File: rtl/core/lfs_outq.sv
`timescale 1ns / 1ps
module lfs_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push0,
	input  logic             push1,
	input  lfs_pkg::result_t res0,
	input  lfs_pkg::result_t res1,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output lfs_pkg::result_t out_res
);
	import lfs_pkg::*;

	localparam int PTR_W = $clog2(OUTQ_DEPTH);
	localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

	result_t          slot_q [OUTQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;
	logic [PTR_W-1:0] wr_ptr_nx;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid & out_ready;
	assign out_res   = slot_q[rd_ptr_q];
	// room for the two beats an end of stream may produce
	assign room      = (cnt_q <= CNT_W'(OUTQ_DEPTH - 2));
	assign wr_ptr_nx = wr_ptr_q + PTR_W'(1);

	// payload slots
	always_ff @(posedge clk) begin
		if (push0) begin
			slot_q[wr_ptr_q] <= res0;
		end
		if (push1) begin
			slot_q[wr_ptr_nx] <= res1;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push0) + PTR_W'(push1);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			cnt_q    <= cnt_q + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
		end
	end

endmodule

// File: rtl/core/lfs_checker.sv
`timescale 1ns / 1ps
module lfs_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [lfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                           m_axis_tuser,
	input logic                           m_axis_tlast
);
	import lfs_pkg::*;

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result beat changed while stalled");

	// a summary is always the final beat and carries no verdict or length
	a_summary: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == RES_SUMMARY |->
			m_axis_tlast && m_axis_tdata[SEL_BIT] == 1'b0
			&& m_axis_tdata[CNT_LSB-1:LEN_LSB] == '0)
		else $error("malformed summary beat");

	// a nonzero count implies some line was selected
	a_count_any: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[ANY_BIT-1:CNT_LSB] != '0 |-> m_axis_tdata[ANY_BIT])
		else $error("count set without any selection");

	// a selected line shows up in the running flag
	a_sel_any: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == RES_LINE && m_axis_tdata[SEL_BIT] |->
			m_axis_tdata[ANY_BIT])
		else $error("selected line without any_selected");

endmodule

bind line_substring_filter lfs_checker u_lfs_checker (.*);

// File: verif/tb_line_substring_filter.sv
`timescale 1ns / 1ps
module tb_line_substring_filter;
	import lfs_pkg::*;

	localparam int LINE_LIMIT    = LINE_BYTES_DEF - 1;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int STALL_CYCLES  = 300;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_BEATS   = 40;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS   = 10;
	localparam int FILL_LINES    = 8;

	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_ALL_ONE = 8'hFF;

	typedef struct packed {
		logic [7:0] data;
		logic       eos;
	} text_beat_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [APB_AW-1:0]     paddr   = '0;
	logic [APB_DW-1:0]     pwdata  = '0;
	logic [APB_DW-1:0]     prdata;
	logic                  pready;

	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata  = '0;  // [7:0] text_byte
	logic                  s_axis_tlast  = 1'b0;  // end_of_stream

	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// [0] line_selected, [10:1] line_length, [42:11] selected_count, [43] any_selected
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;  // result_kind
	logic                  m_axis_tlast;  // last_result

	line_substring_filter DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// settings mirrored from the register writes
	logic [5:0]  cfg_pat_len = '0;
	logic        cfg_fold    = 1'b0;
	logic        cfg_invert  = 1'b0;
	logic [63:0] cfg_words [PAT_WORDS] = '{default: '0};

	// line and count state of the filter
	logic [31:0] match_prefix    = '0;
	logic        line_has_hit    = 1'b0;
	logic        line_text_ended = 1'b0;
	logic [15:0] line_bytes      = '0;
	logic [31:0] select_count    = '0;
	logic        any_select      = 1'b0;

	text_beat_t  text_beats [$];
	result_t     expected_results [$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	logic        stall_request = 1'b0;
	int unsigned stall_left    = 0;

	int unsigned cycle_count    = 0;
	int unsigned error_count    = 0;
	int unsigned gen_count      = 0;
	int unsigned beats_sent     = 0;
	int unsigned verdicts_seen  = 0;
	int unsigned selected_seen  = 0;
	int unsigned summaries_seen = 0;
	int unsigned setups_done    = 0;

	// pattern view of the registers
	function automatic logic [7:0] pattern_byte(input int unsigned i);
		return cfg_words[i / 8][(i % 8) * 8 +: 8];
	endfunction

	function automatic int unsigned active_pattern_len();
		int unsigned n;
		int unsigned i;
		n = (cfg_pat_len > PAT_BYTES) ? PAT_BYTES : cfg_pat_len;
		for (i = 0; i < n; i++) begin
			if (pattern_byte(i) == CHAR_NUL) begin
				return i;
			end
		end
		return n;
	endfunction

	function automatic logic [7:0] fold_char(input logic [7:0] c);
		if (cfg_fold && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			return c + CASE_OFFSET;
		end
		return c;
	endfunction

	function automatic void clear_line();
		match_prefix    = '0;
		line_has_hit    = 1'b0;
		line_text_ended = 1'b0;
		line_bytes      = '0;
	endfunction

	// verdict for the line in progress
	function automatic void close_line(input logic last);
		logic    sel;
		result_t r;
		sel = (active_pattern_len() == 0) || line_has_hit;
		if (cfg_invert) begin
			sel = !sel;
		end
		if (sel) begin
			if (select_count != 32'hFFFF_FFFF) begin
				select_count++;
			end
			any_select = 1'b1;
		end
		r.kind  = RES_LINE;
		r.sel   = sel;
		r.len   = line_bytes[9:0];
		r.count = select_count;
		r.any   = any_select;
		r.last  = last;
		expected_results.push_back(r);
		clear_line();
	endfunction

	// shift-and step for one text byte
	function automatic void scan_byte(input logic [7:0] b);
		int unsigned n;
		int unsigned i;
		logic [31:0] hits;
		logic [7:0]  c;
		line_bytes++;
		if (line_text_ended) begin
			return;
		end
		if (b == CHAR_NUL) begin
			line_text_ended = 1'b1;
			return;
		end
		n = active_pattern_len();
		if (n == 0) begin
			return;
		end
		c    = fold_char(b);
		hits = '0;
		for (i = 0; i < n; i++) begin
			if (fold_char(pattern_byte(i)) == c) begin
				hits[i] = 1'b1;
			end
		end
		match_prefix = ((match_prefix << 1) | 32'd1) & hits;
		if (match_prefix[n - 1]) begin
			line_has_hit = 1'b1;
		end
	endfunction

	function automatic void filter_beat(input text_beat_t beat);
		result_t r;
		if (beat.eos) begin
			if (line_bytes > 0) begin
				close_line(1'b0);
			end
			r.kind  = RES_SUMMARY;
			r.sel   = 1'b0;
			r.len   = '0;
			r.count = select_count;
			r.any   = any_select;
			r.last  = 1'b1;
			expected_results.push_back(r);
			clear_line();
			select_count = '0;
			any_select   = 1'b0;
		end else if (beat.data == CHAR_NEWLINE) begin
			close_line(1'b1);
		end else begin
			if (line_bytes >= LINE_LIMIT) begin
				close_line(1'b1);
			end
			scan_byte(beat.data);
		end
	endfunction

	// text driver
	always @(posedge clk or negedge arst_n) begin : text_driver
		text_beat_t nb;
		text_beat_t taken;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tlast  <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				taken.data = s_axis_tdata;
				taken.eos  = s_axis_tlast;
				filter_beat(taken);
				beats_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (text_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nb = text_beats.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= nb.data;
					s_axis_tlast  <= nb.eos;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off on request
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (stall_request) begin
			stall_left <= STALL_CYCLES;
		end
	end

	// result ready with random stalls
	always @(posedge clk) begin
		m_axis_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
	end

	// result monitor
	always @(posedge clk) begin : result_monitor
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind  = m_axis_tuser;
			got.sel   = m_axis_tdata[SEL_BIT];
			got.len   = m_axis_tdata[LEN_LSB +: 10];
			got.count = m_axis_tdata[CNT_LSB +: 32];
			got.any   = m_axis_tdata[ANY_BIT];
			got.last  = m_axis_tlast;
			if (expected_results.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS) begin
					$display("cycle %0d: unexpected result beat kind=%0d sel=%0d len=%0d cnt=%0d any=%0d last=%0d",
						cycle_count, got.kind, got.sel, got.len, got.count, got.any, got.last);
				end
			end else begin
				want = expected_results.pop_front();
				if (got.kind !== want.kind || got.sel !== want.sel || got.len !== want.len ||
						got.count !== want.count || got.any !== want.any || got.last !== want.last) begin
					error_count++;
					if (error_count <= MAX_REPORTS) begin
						$display("cycle %0d: expected kind=%0d sel=%0d len=%0d cnt=%0d any=%0d last=%0d",
							cycle_count, want.kind, want.sel, want.len, want.count, want.any, want.last);
						$display("cycle %0d: actual   kind=%0d sel=%0d len=%0d cnt=%0d any=%0d last=%0d",
							cycle_count, got.kind, got.sel, got.len, got.count, got.any, got.last);
					end
				end
				if (want.kind == RES_SUMMARY) begin
					summaries_seen++;
				end else begin
					verdicts_seen++;
					if (want.sel) begin
						selected_seen++;
					end
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_PATTERN_LENGTH: cfg_pat_len  = value[5:0];
			REG_FOLD_CASE:      cfg_fold     = value[0];
			REG_INVERT_SELECT:  cfg_invert   = value[0];
			REG_PATTERN_WORD_A: cfg_words[0] = value;
			REG_PATTERN_WORD_B: cfg_words[1] = value;
			REG_PATTERN_WORD_C: cfg_words[2] = value;
			REG_PATTERN_WORD_D: cfg_words[3] = value;
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [5:0] plen, input logic fold, input logic inv,
			input logic [63:0] wa, input logic [63:0] wb, input logic [63:0] wc,
			input logic [63:0] wd);
		reg_write(REG_PATTERN_LENGTH, {58'd0, plen});
		reg_write(REG_FOLD_CASE, {63'd0, fold});
		reg_write(REG_INVERT_SELECT, {63'd0, inv});
		reg_write(REG_PATTERN_WORD_A, wa);
		reg_write(REG_PATTERN_WORD_B, wb);
		reg_write(REG_PATTERN_WORD_C, wc);
		reg_write(REG_PATTERN_WORD_D, wd);
		setups_done++;
		@(negedge clk);
	endtask

	task automatic push_beat(input logic [7:0] b, input logic eos);
		text_beat_t t;
		t.data = b;
		t.eos  = eos;
		text_beats.push_back(t);
		gen_count++;
	endtask

	task automatic push_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) begin
			push_beat(s[i], 1'b0);
		end
	endtask

	function automatic logic [7:0] flip_case(input logic [7:0] c);
		if ((c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) || (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)) begin
			return c ^ CASE_OFFSET;
		end
		return c;
	endfunction

	function automatic logic [7:0] filler_byte();
		int unsigned r;
		int unsigned n;
		logic [7:0]  c;
		r = $urandom_range(99);
		n = active_pattern_len();
		if (r < 55 && n > 0) begin
			c = pattern_byte($urandom_range(n - 1, 0));
		end else if (r < 80) begin
			c = CHAR_LOWER_A + 8'($urandom_range(3));
		end else if (r < 93) begin
			c = 8'($urandom_range(255, 1));
		end else if (r < 96) begin
			c = CHAR_NUL;
		end else begin
			c = 8'($urandom_range(255));
		end
		if ($urandom_range(99) < 25) begin
			c = flip_case(c);
		end
		return c;
	endfunction

	// one line of mixed text, often holding the pattern or a prefix of it
	task automatic add_line(input int unsigned max_len);
		int unsigned n;
		int unsigned at;
		int unsigned keep;
		int unsigned plen;
		int unsigned i;
		int unsigned j;
		logic [7:0]  c;
		plen = active_pattern_len();
		n    = $urandom_range(max_len, 0);
		at   = n + 1;
		keep = 0;
		if (plen > 0 && $urandom_range(99) < 60) begin
			at   = $urandom_range(n, 0);
			keep = ($urandom_range(99) < 70) ? plen : $urandom_range(plen, 1);
		end
		for (i = 0; i <= n; i++) begin
			if (i == at) begin
				for (j = 0; j < keep; j++) begin
					c = pattern_byte(j);
					if ($urandom_range(99) < 15) begin
						c = flip_case(c);
					end
					push_beat(c, 1'b0);
				end
			end
			if (i < n) begin
				push_beat(filler_byte(), 1'b0);
			end
		end
		if ($urandom_range(99) < 92) begin
			push_beat(CHAR_NEWLINE, 1'b0);
		end else begin
			push_beat(8'($urandom_range(255)), 1'b1);
		end
	endtask

	task automatic random_setup();
		logic [7:0]  pat [PAT_BYTES];
		logic [63:0] w [PAT_WORDS];
		logic [5:0]  plen;
		int unsigned r;
		int unsigned i;
		r = $urandom_range(19);
		if (r == 0) begin
			plen = 6'd0;
		end else if (r == 1) begin
			plen = 6'd32;
		end else if (r == 2) begin
			plen = 6'($urandom_range(63, 33));
		end else if (r < 6) begin
			plen = 6'($urandom_range(31, 9));
		end else begin
			plen = 6'($urandom_range(8, 1));
		end
		for (i = 0; i < PAT_BYTES; i++) begin
			pat[i] = CHAR_LOWER_A + 8'($urandom_range(3));
			if ($urandom_range(1)) begin
				pat[i] = flip_case(pat[i]);
			end
		end
		r = $urandom_range(9);
		if (r == 0) begin
			pat[$urandom_range(PAT_BYTES - 1)] = CHAR_NUL;
		end else if (r == 1) begin
			for (i = 0; i < PAT_BYTES; i++) begin
				pat[i] = 8'($urandom_range(255));
			end
		end
		for (i = 0; i < PAT_BYTES; i++) begin
			w[i / 8][(i % 8) * 8 +: 8] = pat[i];
		end
		if (r == 2) begin
			for (i = 0; i < PAT_WORDS; i++) begin
				w[i] = '1;
			end
		end
		write_all(plen, 1'($urandom_range(1)), 1'($urandom_range(1)), w[0], w[1], w[2], w[3]);
	endtask

	task automatic set_idle(input int unsigned mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
			1: begin send_idle_pct = 53; recv_idle_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_idle_pct = 53; end
			default: begin send_idle_pct = 36; recv_idle_pct = 36; end
		endcase
	endtask

	// hold the next config write until the block has gone quiet
	task automatic wait_drain();
		while (text_beats.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic push_filler(input int unsigned count);
		int unsigned i;
		for (i = 0; i < count; i++) begin
			push_beat(CHAR_LOWER_A + 8'($urandom_range(24)), 1'b0);
		end
	endtask

	task automatic push_repeat(input logic [7:0] b, input int unsigned count);
		int unsigned i;
		for (i = 0; i < count; i++) begin
			push_beat(b, 1'b0);
		end
	endtask

	initial begin : stimulus
		int unsigned ph;
		int unsigned start;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty pattern after reset: every line selected, empty final line
		push_text("\n");
		push_text("hi\n");
		push_beat(CHAR_ALL_ONE, 1'b1);
		push_beat(CHAR_NUL, 1'b1);
		wait_drain();

		// plain pattern, zero byte ending the text, pending line flushed at end
		write_all(6'd3, 1'b0, 1'b0, 64'h0000_0000_0063_6261, '0, '0, '0);
		push_text("xabcx\n");
		push_text("ABC\n");
		push_text("ab");
		push_beat(CHAR_NUL, 1'b0);
		push_text("abc\n");
		push_text("aab");
		push_beat(CHAR_NUL, 1'b1);
		wait_drain();

		// folded case and inverted verdict
		reg_write(REG_FOLD_CASE, 64'd1);
		reg_write(REG_INVERT_SELECT, 64'd1);
		@(negedge clk);
		push_text("xABcy\n");
		push_text("\n");
		wait_drain();

		// oversized length with a zero byte cutting the pattern to two bytes
		write_all(6'd63, 1'b1, 1'b0, 64'h6363_6363_6300_6261, '1, '1, '1);
		push_text("xxAb\n");
		push_text("b a\n");
		push_beat(CHAR_NEWLINE, 1'b1);
		wait_drain();

		// random settings and text across the idle phases
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			random_setup();
			set_idle(ph % 4);
			start = gen_count;
			while (gen_count - start < PHASE_BEATS) begin
				add_line((ph % 3 == 2) ? 60 : 24);
			end
			if (ph % 2 == 1) begin
				push_beat(8'($urandom_range(255)), 1'b1);
			end
			if (ph == 4) begin
				// short lines so the held-off results fill the queue
				push_repeat(CHAR_NEWLINE, FILL_LINES);
				stall_request <= 1'b1;
				while (stall_left == 0) begin
					@(negedge clk);
				end
				stall_request <= 1'b0;
			end
			wait_drain();
		end

		// full-size line with a 32-byte all-ones pattern
		write_all(6'd32, 1'b0, 1'b0, '1, '1, '1, '1);
		set_idle(3);
		// 31 pattern bytes close a full line, the split byte must not complete a match
		push_filler(LINE_LIMIT - 31);
		push_repeat(CHAR_ALL_ONE, 31);
		push_beat(CHAR_ALL_ONE, 1'b0);
		push_text("ab\n");
		push_beat(CHAR_NUL, 1'b1);
		wait_drain();

		$display("%0d text beats over %0d register settings and four idle mixes", beats_sent,
			setups_done);
		$display("%0d line verdicts (%0d selected), %0d stream summaries", verdicts_seen,
			selected_seen, summaries_seen);
		if (error_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", error_count);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/lfs_pkg.sv
rtl/core/lfs_cell.sv
rtl/core/lfs_regs.sv
rtl/core/lfs_outq.sv
rtl/core/line_substring_filter.sv
rtl/core/lfs_checker.sv
verif/tb_line_substring_filter.sv
